[design/assert_macros.svh]
// assertion macros shared by the indent layout tracker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ILT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ILT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/ilt_pkg.sv]
// shared constants, codes and helpers for the indent layout tracker
`timescale 1ns / 1ps

package ilt_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int COLUMN_BITS = 16;
	localparam int MAX_RESULTS = 32;
	localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
	localparam int FIELD_COL_W = 16;

	typedef logic [2:0] kind_t;
	typedef logic [1:0] req_t;
	typedef logic [1:0] ichar_t;

	// result kinds
	localparam kind_t K_NEWLINE  = 3'd0;
	localparam kind_t K_INDENT   = 3'd1;
	localparam kind_t K_UNINDENT = 3'd2;
	localparam kind_t K_ERROR    = 3'd3;
	localparam kind_t K_MIXED    = 3'd4;
	localparam kind_t K_PAREN    = 3'd5;
	localparam kind_t K_OVERFLOW = 3'd6;

	// request types
	localparam req_t REQ_CHAR  = 2'd0;
	localparam req_t REQ_OPEN  = 2'd1;
	localparam req_t REQ_CLOSE = 2'd2;
	localparam req_t REQ_END   = 2'd3;

	// first indentation character seen
	localparam ichar_t IC_NONE  = 2'd0;
	localparam ichar_t IC_SPACE = 2'd1;
	localparam ichar_t IC_TAB   = 2'd2;

	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'd32;

	function automatic logic is_ws(input logic [7:0] c);
		return c inside {[8'd9:8'd13], CH_SPACE};
	endfunction

endpackage

[design/ilt_stack.sv]
// indent column stack storage, one write port and one registered read port
`timescale 1ns / 1ps

module ilt_stack #(
	parameter int DEPTH = ilt_pkg::STACK_DEPTH,
	parameter int WIDTH = ilt_pkg::COLUMN_BITS,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/indent_layout_tracker_unit.sv]
// top level of the indent layout tracker: sequencer, line state and result buffering
`timescale 1ns / 1ps
//
// indent layout tracker (offside rule)
// request channel (req_valid / req_stall): one transaction per source character
//   between tokens, open paren, close paren (with the indent and mode saved at the
//   matching open) or end of input
// result channel (res_valid / res_stall): zero or more transactions per request,
//   the final one of a request carries last = 1
// a request passes through the drain, work, drain and fin states, plus a drain and wait
//   pair for every unindent popped and a wait for an entry popped by a close paren; each
//   pop is a registered stack memory read before the new top can be compared
// requests are processed one at a time; req_stall is high while one is in flight
// results go through a one-entry hold stage so the last flag can be set once the
//   request is done, then through the output register
// when res_stall is high the sequencer waits only when it needs to emit and both
//   the hold stage and the output register are full
// reset leaves the stack with its base entry (column 0), all line state cleared;
//   no clearing pass is needed since only written entries are ever read back
// after end of input every request is taken in idle and dropped until reset
//
module indent_layout_tracker_unit #(
	parameter int STACK_DEPTH = ilt_pkg::STACK_DEPTH,
	parameter int COLUMN_BITS = ilt_pkg::COLUMN_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	// request channel
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [1:0]          req_type,
	input  logic [7:0]          char_code,
	input  logic [15:0]         restore_indent,
	input  logic                restore_setting,
	// result channel
	output logic                res_valid,
	input  logic                res_stall,
	output logic [2:0]          token_kind,
	output logic [15:0]         column,
	output logic [15:0]         saved_indent,
	output logic                saved_setting,
	output logic                last
);

`include "assert_macros.svh"

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int CB = COLUMN_BITS;
	localparam int FW = ilt_pkg::FIELD_COL_W;
	localparam int NW = ilt_pkg::NRES_W;

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;  // waiting for a request
	localparam logic [2:0] S_DRAIN  = 3'd1;  // pop pending unindents
	localparam logic [2:0] S_WAITD  = 3'd2;  // stack read after a drain pop
	localparam logic [2:0] S_WORK   = 3'd3;  // the request's own work
	localparam logic [2:0] S_WAITU  = 3'd4;  // stack read after a line-start pop
	localparam logic [2:0] S_UNEMIT = 3'd5;  // report unindent or error
	localparam logic [2:0] S_FIN    = 3'd6;  // release held result with last set

	logic [2:0] state_q, state_d;
	logic       ph_q, ph_d;        // 0 before the work, 1 after
	logic [NW-1:0] nres_q, nres_d;

	// captured request
	logic [1:0]  type_q;
	logic [7:0]  char_q;
	logic [15:0] rind_q;
	logic        rset_q;

	// layout state; the stack itself lives in ilt_stack, its top is cached in top_q
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CB-1:0] top_q, top_d;
	logic [CB-1:0] cur_q, cur_d;
	logic          lss_q, lss_d;   // line start pending
	logic          set_q, set_d;   // set-indent mode
	logic [CB-1:0] ws_q, ws_d;
	logic [1:0]    fic_q, fic_d;
	logic          ended_q, ended_d;

	// hold stage
	logic          hold_v_q;
	logic [2:0]    hold_kind_q;
	logic [FW-1:0] hold_col_q;
	logic [FW-1:0] hold_si_q;
	logic          hold_ss_q;

	// output register
	logic          res_valid_q;
	logic [2:0]    kind_q;
	logic [FW-1:0] col_q;
	logic [FW-1:0] si_q;
	logic          ss_q;
	logic          last_q;

	// stack port
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [CB-1:0] mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [CB-1:0] rd_data;

	// emit request from the sequencer
	logic          em_req;
	logic [2:0]    em_kind;
	logic [CB-1:0] em_col;
	logic [CB-1:0] em_si;
	logic          em_ss;
	logic          em_fire;
	logic          emit_ok;
	logic          flush;

	logic [CB+FW-1:0] em_col_x;
	logic [CB+FW-1:0] em_si_x;
	logic [CB+FW-1:0] rind_x;
	logic [CB-1:0]    rind_c;
	logic [CW-1:0]    cnt_m2;
	logic [CB-1:0]    ws_inc;
	logic [1:0]       kind_k;
	logic             ch_ws;
	logic             ch_nl;
	logic             ch_ind;
	logic             push_ok;
	logic             drain_more;
	logic [NW-1:0]    lim;
	logic             do_settle;
	logic             base_settled;

	ilt_stack #(
		.DEPTH(STACK_DEPTH),
		.WIDTH(COLUMN_BITS)
	) u_stack (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd_data)
	);

	// one request in flight at a time
	assign req_stall = (state_q != S_IDLE);

	// a new result can enter the hold stage if it is empty or its content can move on
	assign emit_ok = !hold_v_q || !res_valid_q || !res_stall;

	// column widths: internal COLUMN_BITS against the 16-bit fields
	assign rind_x = {{CB{1'b0}}, rind_q};
	assign rind_c = rind_x[CB-1:0];
	assign em_col_x = {{FW{1'b0}}, em_col};
	assign em_si_x  = {{FW{1'b0}}, em_si};

	assign cnt_m2  = cnt_q - CW'(2);
	assign push_ok = (cnt_q < CW'(STACK_DEPTH));
	assign lim     = ph_q ? NW'(ilt_pkg::MAX_RESULTS) : NW'(ilt_pkg::MAX_RESULTS - 1);
	assign drain_more = (cnt_q > CW'(1)) && (top_q > cur_q) && (nres_q < lim);

	// cached top is current except while a stack read is outstanding
	assign base_settled = (cnt_q == CW'(1)) && (state_q != S_WAITD) && (state_q != S_WAITU);

	// character classification
	assign ch_ws  = ilt_pkg::is_ws(char_q);
	assign ch_nl  = (char_q == ilt_pkg::CH_NL);
	assign ch_ind = (char_q == ilt_pkg::CH_SPACE) || (char_q == ilt_pkg::CH_TAB);
	assign kind_k = (char_q == ilt_pkg::CH_SPACE) ? ilt_pkg::IC_SPACE : ilt_pkg::IC_TAB;
	// leading whitespace count saturates at the column limit
	assign ws_inc = (ws_q != {CB{1'b1}}) ? ws_q + CB'(1) : ws_q;

	always_comb begin
		state_d   = state_q;
		ph_d      = ph_q;
		nres_d    = nres_q;
		cnt_d     = cnt_q;
		top_d     = top_q;
		cur_d     = cur_q;
		lss_d     = lss_q;
		set_d     = set_q;
		ws_d      = ws_q;
		fic_d     = fic_q;
		ended_d   = ended_q;
		em_req    = 1'b0;
		em_kind   = ilt_pkg::K_NEWLINE;
		em_col    = '0;
		em_si     = '0;
		em_ss     = 1'b0;
		flush     = 1'b0;
		do_settle = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cnt_q[AW-1:0];
		mem_wdata = cur_q;
		mem_re    = 1'b0;
		mem_raddr = cnt_m2[AW-1:0];

		case (state_q)
			S_IDLE: begin
				// after end of input requests are taken and dropped
				if (req_valid && !ended_q) begin
					state_d = S_DRAIN;
					ph_d    = 1'b0;
					nres_d  = '0;
				end
			end
			S_DRAIN: begin
				if (drain_more) begin
					em_req  = 1'b1;
					em_kind = ilt_pkg::K_UNINDENT;
					em_col  = cur_q;
					if (emit_ok) begin
						cnt_d   = cnt_q - CW'(1);
						mem_re  = 1'b1;
						state_d = S_WAITD;
					end
				end else if (!ph_q) begin
					state_d = S_WORK;
				end else begin
					state_d = S_FIN;
				end
			end
			S_WAITD: begin
				// base entry always holds column 0 and is never written
				top_d   = (cnt_q == CW'(1)) ? '0 : rd_data;
				state_d = S_DRAIN;
			end
			S_WORK: begin
				ph_d    = 1'b1;
				state_d = S_DRAIN;
				case (type_q)
					ilt_pkg::REQ_CHAR: begin
						if (ch_nl) begin
							lss_d = 1'b1;
							ws_d  = '0;
						end else if (ch_ws) begin
							if (lss_q) begin
								ws_d = ws_inc;
								if (ch_ind) begin
									if (fic_q == ilt_pkg::IC_NONE) begin
										fic_d = kind_k;
									end else if (fic_q != kind_k) begin
										em_req  = 1'b1;
										em_kind = ilt_pkg::K_MIXED;
										em_col  = ws_inc;
									end
								end
							end
						end else if (lss_q) begin
							do_settle = 1'b1;
						end
					end
					ilt_pkg::REQ_OPEN: begin
						em_req  = 1'b1;
						em_kind = ilt_pkg::K_PAREN;
						em_col  = cur_q;
						em_si   = cur_q;
						em_ss   = set_q;
						set_d   = 1'b1;
					end
					ilt_pkg::REQ_CLOSE: begin
						cur_d = rind_c;
						set_d = rset_q;
						if (!set_q && (cnt_q > CW'(1)) && (top_q == rind_c)) begin
							cnt_d   = cnt_q - CW'(1);
							mem_re  = 1'b1;
							state_d = S_WAITD;
						end
					end
					ilt_pkg::REQ_END: begin
						ended_d = 1'b1;
						if (lss_q) begin
							do_settle = 1'b1;
						end
					end
					default: begin
						state_d = S_DRAIN;
					end
				endcase

				// first non-whitespace character of a line
				if (do_settle) begin
					lss_d = 1'b0;
					if (set_q) begin
						// set-indent mode: save the old indent, take this column
						em_req  = 1'b1;
						em_kind = push_ok ? ilt_pkg::K_NEWLINE : ilt_pkg::K_OVERFLOW;
						em_col  = ws_q;
						cur_d   = ws_q;
						set_d   = 1'b0;
						if (push_ok) begin
							mem_we    = 1'b1;
							mem_wdata = cur_q;
							top_d     = cur_q;
							cnt_d     = cnt_q + CW'(1);
						end
					end else if (ws_q > cur_q) begin
						em_req  = 1'b1;
						em_kind = push_ok ? ilt_pkg::K_INDENT : ilt_pkg::K_OVERFLOW;
						em_col  = ws_q;
						cur_d   = ws_q;
						if (push_ok) begin
							mem_we    = 1'b1;
							mem_wdata = ws_q;
							top_d     = ws_q;
							cnt_d     = cnt_q + CW'(1);
						end
					end else if (ws_q < top_q) begin
						// pop, then compare against the new top to tell error from unindent
						cur_d = ws_q;
						if (cnt_q > CW'(1)) begin
							cnt_d   = cnt_q - CW'(1);
							mem_re  = 1'b1;
							state_d = S_WAITU;
						end else begin
							state_d = S_UNEMIT;
						end
					end else begin
						em_req  = 1'b1;
						em_kind = ilt_pkg::K_NEWLINE;
						em_col  = cur_q;
					end
				end

				// result path full: retry the whole step next cycle
				if (em_req && !emit_ok) begin
					state_d = state_q;
					ph_d    = ph_q;
					cnt_d   = cnt_q;
					top_d   = top_q;
					cur_d   = cur_q;
					lss_d   = lss_q;
					set_d   = set_q;
					ws_d    = ws_q;
					fic_d   = fic_q;
					ended_d = ended_q;
					mem_we  = 1'b0;
					mem_re  = 1'b0;
				end
			end
			S_WAITU: begin
				top_d   = (cnt_q == CW'(1)) ? '0 : rd_data;
				state_d = S_UNEMIT;
			end
			S_UNEMIT: begin
				em_req  = 1'b1;
				em_kind = (top_q < cur_q) ? ilt_pkg::K_ERROR : ilt_pkg::K_UNINDENT;
				em_col  = cur_q;
				if (emit_ok) begin
					ph_d    = 1'b1;
					state_d = S_DRAIN;
				end
			end
			S_FIN: begin
				if (!hold_v_q || !res_valid_q || !res_stall) begin
					flush   = hold_v_q;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		em_fire = em_req && emit_ok;
		if (em_fire) begin
			nres_d = nres_q + NW'(1);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= 1'b0;
			nres_q      <= '0;
			cnt_q       <= CW'(1);
			top_q       <= '0;
			cur_q       <= '0;
			lss_q       <= 1'b0;
			set_q       <= 1'b0;
			ws_q        <= '0;
			fic_q       <= ilt_pkg::IC_NONE;
			ended_q     <= 1'b0;
			hold_v_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
			nres_q  <= nres_d;
			cnt_q   <= cnt_d;
			top_q   <= top_d;
			cur_q   <= cur_d;
			lss_q   <= lss_d;
			set_q   <= set_d;
			ws_q    <= ws_d;
			fic_q   <= fic_d;
			ended_q <= ended_d;

			if (em_fire) begin
				hold_v_q <= 1'b1;
			end else if (flush) begin
				hold_v_q <= 1'b0;
			end

			if ((em_fire && hold_v_q) || flush) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			type_q <= req_type;
			char_q <= char_code;
			rind_q <= restore_indent;
			rset_q <= restore_setting;
		end

		// a new result pushes the held one out, which was not the last; the flush moves it out with last set
		if ((em_fire && hold_v_q) || flush) begin
			kind_q <= hold_kind_q;
			col_q  <= hold_col_q;
			si_q   <= hold_si_q;
			ss_q   <= hold_ss_q;
			last_q <= flush;
		end

		if (em_fire) begin
			hold_kind_q <= em_kind;
			hold_col_q  <= em_col_x[FW-1:0];
			hold_si_q   <= em_si_x[FW-1:0];
			hold_ss_q   <= em_ss;
		end
	end

	assign res_valid     = res_valid_q;
	assign token_kind    = kind_q;
	assign column        = col_q;
	assign saved_indent  = si_q;
	assign saved_setting = ss_q;
	assign last          = last_q;

	// stack depth stays between the base entry and full
	`ILT_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, (cnt_q != '0) && (cnt_q <= CW'(STACK_DEPTH)), "stack count out of range")
	// with only the base entry left the cached top is column 0
	`ILT_ASSERT_IMP(a_base_top, clk, arst_n, base_settled, top_q == '0, "base entry top not zero")
	// no result may be left in the hold stage between requests
	`ILT_ASSERT_IMP(a_idle_hold, clk, arst_n, state_q == S_IDLE, !hold_v_q, "held result left at idle")
	// every stack read is consumed by a wait state in the next cycle
	`ILT_ASSERT_NXT(a_pop_wait, clk, arst_n, mem_re, (state_q == S_WAITD) || (state_q == S_WAITU), "stack read not followed by wait")

endmodule

[tb/ilt_token_checker.sv]
`timescale 1ns / 1ps
// checker for the indent layout tracker: predicts token transactions and compares them
module ilt_token_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  char_code,
	input  logic [15:0] restore_indent,
	input  logic        restore_setting,
	input  logic        res_valid,
	input  logic        res_stall,
	input  logic [2:0]  token_kind,
	input  logic [15:0] column,
	input  logic [15:0] saved_indent,
	input  logic        saved_setting,
	input  logic        last,
	output int          fails,
	output int          pending
);

	typedef struct packed {
		ilt_pkg::kind_t kind;
		logic [15:0]    column;
		logic [15:0]    saved_indent;
		logic           saved_setting;
		logic           last;
	} token_t;

	// predicted layout state
	logic [15:0]     col_stack [ilt_pkg::STACK_DEPTH];
	int              col_depth;
	logic [15:0]     cur_col;
	logic [15:0]     ws_run;
	logic            line_open;
	logic            set_mode;
	logic            ended;
	ilt_pkg::ichar_t first_ws;

	token_t step_tokens[$];
	token_t expected_tokens[$];
	int     mismatches;

	function automatic logic [15:0] stack_head();
		return col_stack[col_depth - 1];
	endfunction

	task automatic put(ilt_pkg::kind_t kind, logic [15:0] col, logic [15:0] si, logic ss);
		token_t tok;
		tok = '{kind, col, si, ss, 1'b0};
		if (step_tokens.size() < ilt_pkg::MAX_RESULTS)
			step_tokens.insert(step_tokens.size(), tok);
	endtask

	// pop stack entries right of the current indent while the step stays under the cap
	task automatic pop_pending(int cap);
		while (step_tokens.size() < cap && col_depth > 1 && stack_head() > cur_col) begin
			col_depth--;
			put(ilt_pkg::K_UNINDENT, cur_col, '0, 1'b0);
		end
	endtask

	task automatic settle_line();
		logic [15:0] col;
		logic        fits;
		col = ws_run;
		line_open = 1'b0;
		fits = col_depth < ilt_pkg::STACK_DEPTH;
		if (set_mode) begin
			if (fits) begin
				col_stack[col_depth] = cur_col;
				col_depth++;
			end
			cur_col = col;
			set_mode = 1'b0;
			put(fits ? ilt_pkg::K_NEWLINE : ilt_pkg::K_OVERFLOW, col, '0, 1'b0);
		end else if (col > cur_col) begin
			cur_col = col;
			if (fits) begin
				col_stack[col_depth] = col;
				col_depth++;
			end
			put(fits ? ilt_pkg::K_INDENT : ilt_pkg::K_OVERFLOW, col, '0, 1'b0);
		end else if (col < stack_head()) begin
			if (col_depth > 1)
				col_depth--;
			cur_col = col;
			put(stack_head() < col ? ilt_pkg::K_ERROR : ilt_pkg::K_UNINDENT, col, '0, 1'b0);
		end else begin
			put(ilt_pkg::K_NEWLINE, cur_col, '0, 1'b0);
		end
	endtask

	task automatic advance_layout(ilt_pkg::req_t kind, logic [7:0] c, logic [15:0] ri,
		logic rs);
		ilt_pkg::ichar_t ic;
		if (ended)
			return;
		step_tokens.delete();
		pop_pending(ilt_pkg::MAX_RESULTS - 1);
		case (kind)
			ilt_pkg::REQ_CHAR: begin
				if ((c >= 8'd9 && c <= 8'd13) || c == ilt_pkg::CH_SPACE) begin
					if (c == ilt_pkg::CH_NL) begin
						line_open = 1'b1;
						ws_run = '0;
					end else if (line_open) begin
						if (ws_run != '1)
							ws_run++;
						if (c == ilt_pkg::CH_SPACE || c == ilt_pkg::CH_TAB) begin
							ic = (c == ilt_pkg::CH_SPACE) ? ilt_pkg::IC_SPACE : ilt_pkg::IC_TAB;
							if (first_ws == ilt_pkg::IC_NONE)
								first_ws = ic;
							else if (first_ws != ic)
								put(ilt_pkg::K_MIXED, ws_run, '0, 1'b0);
						end
					end
				end else if (line_open) begin
					settle_line();
				end
			end
			ilt_pkg::REQ_OPEN: begin
				put(ilt_pkg::K_PAREN, cur_col, cur_col, set_mode);
				set_mode = 1'b1;
			end
			ilt_pkg::REQ_CLOSE: begin
				cur_col = ri;
				if (!set_mode && col_depth > 1 && stack_head() == cur_col)
					col_depth--;
				set_mode = rs;
			end
			default: begin
				if (line_open)
					settle_line();
				ended = 1'b1;
			end
		endcase
		pop_pending(ilt_pkg::MAX_RESULTS);
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].last = 1'b1;
		foreach (step_tokens[i])
			expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
	endtask

	task automatic report(string what, int got, int want);
		mismatches++;
		if (mismatches <= 50)
			$display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	task automatic check_token(token_t got);
		token_t want;
		if (expected_tokens.size() == 0) begin
			report("token_kind of unexpected token", got.kind, -1);
			return;
		end
		want = expected_tokens.pop_front();
		if (got.kind != want.kind)
			report("token_kind", got.kind, want.kind);
		if (got.column != want.column)
			report("column", got.column, want.column);
		if (got.saved_indent != want.saved_indent)
			report("saved_indent", got.saved_indent, want.saved_indent);
		if (got.saved_setting != want.saved_setting)
			report("saved_setting", got.saved_setting, want.saved_setting);
		if (got.last != want.last)
			report("last", got.last, want.last);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (col_stack[i])
				col_stack[i] = '0;
			col_depth = 1;
			cur_col = '0;
			ws_run = '0;
			line_open = 1'b0;
			set_mode = 1'b0;
			ended = 1'b0;
			first_ws = ilt_pkg::IC_NONE;
			expected_tokens.delete();
			mismatches = 0;
			fails <= 0;
			pending <= 0;
		end else begin
			if (req_valid && !req_stall)
				advance_layout(ilt_pkg::req_t'(req_type), char_code, restore_indent,
					restore_setting);
			if (res_valid && !res_stall)
				check_token('{ilt_pkg::kind_t'(token_kind), column, saved_indent,
					saved_setting, last});
			fails <= mismatches;
			pending <= expected_tokens.size();
		end
	end

endmodule

[tb/tb_indent_layout_tracker_unit.sv]
`timescale 1ns / 1ps
// testbench top for the indent layout tracker: stimulus, idling, watchdog and verdict
module tb_indent_layout_tracker_unit;

	localparam int ITEM_TARGET   = 500;
	localparam int QUIET_LIMIT   = 5000;   // cycles with no transaction on either channel
	localparam int HOLD_CYCLES   = 400;    // long receiver hold-off to back up the block
	localparam int SETTLE_CYCLES = 100;    // margin after the drain for any stray transaction

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	// request channel
	logic          req_valid = 1'b0;
	logic          req_stall;
	ilt_pkg::req_t req_type = ilt_pkg::REQ_CHAR;
	logic [7:0]    char_code = '0;
	logic [15:0]   restore_indent = '0;
	logic          restore_setting = 1'b0;

	// result channel
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [2:0]  token_kind;
	logic [15:0] column;
	logic [15:0] saved_indent;
	logic        saved_setting;
	logic        last;

	int          fails;
	int          pending;

	// calm: stretch with no idling on either side
	logic        calm = 1'b0;
	logic        hold_off = 1'b0;
	int          stall_left = 0;
	int          quiet = 0;
	int          sent = 0;

	// rough stimulus-side view of the layout, only to keep close parens plausible
	logic [15:0] line_col = '0;
	logic        in_set = 1'b0;
	logic [16:0] open_saves[$];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	indent_layout_tracker_unit i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.req_type        (req_type),
		.char_code       (char_code),
		.restore_indent  (restore_indent),
		.restore_setting (restore_setting),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.token_kind      (token_kind),
		.column          (column),
		.saved_indent    (saved_indent),
		.saved_setting   (saved_setting),
		.last            (last)
	);

	ilt_token_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.req_type        (req_type),
		.char_code       (char_code),
		.restore_indent  (restore_indent),
		.restore_setting (restore_setting),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.token_kind      (token_kind),
		.column          (column),
		.saved_indent    (saved_indent),
		.saved_setting   (saved_setting),
		.last            (last),
		.fails           (fails),
		.pending         (pending)
	);

	// receiver: after each accepted transaction draw the stall for the next one
	always @(posedge clk) begin
		if (res_valid && !res_stall)
			stall_left = calm ? 0 : $urandom_range(0, 18);
		else if (stall_left > 0)
			stall_left = stall_left - 1;
		res_stall <= hold_off || stall_left > 0;
	end

	// watchdog: counts cycles in which neither channel moves a transaction
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// offer one request after a random gap and hold it until taken
	// fields unused by the request type get random values
	task automatic send(ilt_pkg::req_t kind, logic [7:0] c, logic [15:0] ri, logic rs);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= kind;
		char_code <= (kind == ilt_pkg::REQ_CHAR) ? c : 8'($urandom_range(0, 255));
		restore_indent <= (kind == ilt_pkg::REQ_CLOSE) ? ri : 16'($urandom_range(0, 65535));
		restore_setting <= (kind == ilt_pkg::REQ_CLOSE) ? rs : 1'($urandom_range(0, 1));
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_char(logic [7:0] c);
		send(ilt_pkg::REQ_CHAR, c, '0, 1'b0);
	endtask

	// newline, col indentation characters, then one visible character
	// tab_pct: share of tabs; a few vertical tab, form feed and carriage return
	task automatic send_line(int col, int tab_pct, logic [7:0] body);
		int r;
		send_char(ilt_pkg::CH_NL);
		for (int i = 0; i < col; i++) begin
			r = $urandom_range(0, 99);
			if (r < tab_pct)
				send_char(ilt_pkg::CH_TAB);
			else if (r >= 97)
				send_char(8'($urandom_range(11, 13)));
			else
				send_char(ilt_pkg::CH_SPACE);
		end
		send_char(body);
		line_col = (col > 65535) ? 16'hFFFF : 16'(col);
		in_set = 1'b0;
	endtask

	// most recent open paren's saved indent and mode, taken off the list
	task automatic take_latest_save(output logic [16:0] v);
		v = open_saves[open_saves.size() - 1];
		open_saves.delete(open_saves.size() - 1);
	endtask

	// open paren: the character itself, then the event
	task automatic paren_open();
		send_char(8'd40);
		send(ilt_pkg::REQ_OPEN, '0, '0, 1'b0);
		open_saves.insert(open_saves.size(), {in_set, line_col});
		in_set = 1'b1;
	endtask

	task automatic paren_close(logic [15:0] ri, logic rs);
		send_char(8'd41);
		send(ilt_pkg::REQ_CLOSE, '0, ri, rs);
		line_col = ri;
		in_set = rs;
	endtask

	function automatic logic [7:0] visible_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while ((c >= 8'd9 && c <= 8'd13) || c == ilt_pkg::CH_SPACE);
		return c;
	endfunction

	initial begin
		int         r;
		int         col;
		int         round;
		logic       held;
		logic [16:0] sv;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// whitespace and text before the first newline leave no trace
		send_char(ilt_pkg::CH_SPACE);
		send_char(ilt_pkg::CH_TAB);
		send_char(8'd97);

		// indent, same line, deeper, then a drop past two levels
		send_line(4, 0, 8'd120);
		send_line(4, 0, 8'd120);
		send_line(8, 0, 8'd120);
		send_line(2, 0, 8'd120);
		// indent then an unindent to a column never pushed
		send_line(4, 0, 8'd120);
		send_line(3, 0, 8'd120);
		paren_close(16'd0, 1'b0);

		// tab after spaces in indentation, then the other whitespace codes
		send_char(ilt_pkg::CH_NL);
		send_char(ilt_pkg::CH_SPACE);
		send_char(ilt_pkg::CH_TAB);
		send_char(8'd11);
		send_char(8'd12);
		send_char(8'd13);
		send_char(8'd255);
		line_col = 16'd5;

		// nested parens in set-indent mode, a line inside, both closed
		paren_open();
		paren_open();
		send_line(9, 0, 8'd0);
		take_latest_save(sv);
		paren_close(sv[15:0], sv[16]);
		take_latest_save(sv);
		paren_close(sv[15:0], sv[16]);
		paren_close(16'd0, 1'b0);

		// long run without idling: fill the stack in set-indent mode at one column
		// past its depth, overflow on an indent too, then a close paren back to
		// column zero unwinds it in one burst of unindents
		calm <= 1'b1;
		send_line(1, 0, 8'd120);
		for (int i = 0; i < ilt_pkg::STACK_DEPTH; i++) begin
			send(ilt_pkg::REQ_OPEN, '0, '0, 1'b0);
			send_line(1, 0, 8'd120);
		end
		send_line(2, 0, 8'd120);
		paren_close(16'd0, 1'b0);

		// random part: mostly well-formed lines and paren pairs, some noise
		held = 1'b0;
		round = 0;
		while (sent < ITEM_TARGET) begin
			round++;
			if (round % 20 == 19)
				calm <= ($urandom_range(0, 3) == 0);
			// long receiver hold-off while requests keep coming
			if (!held && sent > ITEM_TARGET / 2) begin
				held = 1'b1;
				fork
					begin
						hold_off <= 1'b1;
						repeat (HOLD_CYCLES) @(posedge clk);
						hold_off <= 1'b0;
					end
				join_none
			end
			r = $urandom_range(0, 99);
			if (r < 55) begin
				col = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 20)
					: $urandom_range(0, 5) * 4;
				send_line(col, ($urandom_range(0, 9) == 0) ? 20 : 0, visible_char());
				if ($urandom_range(0, 3) == 0)
					paren_open();
			end else if (r < 72) begin
				if (open_saves.size() > 0 && $urandom_range(0, 7) != 0) begin
					take_latest_save(sv);
					paren_close(sv[15:0], sv[16]);
				end else begin
					paren_close(16'($urandom_range(0, 24)), 1'($urandom_range(0, 1)));
				end
			end else if (r < 85) begin
				paren_open();
			end else begin
				// noise: any request but end of input, any field value
				send(ilt_pkg::req_t'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
					16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
			end
		end

		// end of input with a line start still open, then requests that are dropped
		send_char(ilt_pkg::CH_NL);
		send_char(ilt_pkg::CH_SPACE);
		send_char(ilt_pkg::CH_SPACE);
		send_char(ilt_pkg::CH_SPACE);
		send(ilt_pkg::REQ_END, '0, '0, 1'b0);
		repeat (3)
			send(ilt_pkg::req_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
				16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
		req_valid <= 1'b0;

		// drain, then a margin for any stray transaction
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fails == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
